// ----- design/abck_pkg.sv -----
package abck_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned KeyW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegAlphaMax = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAlphaChanOn = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPaletteMode = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPaletteAlphaOn = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKeyColor = 3'd5;
  localparam logic [CfgIdxW-1:0] RegKeyIndex = 3'd6;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'd255;
  localparam logic [ChanW-1:0] AlphaClear = 8'd0;

  typedef struct packed {
    logic [ChanW-1:0] src_blue;
    logic [ChanW-1:0] src_green;
    logic [ChanW-1:0] src_red;
    logic [ChanW-1:0] src_alpha;
    logic [ChanW-1:0] entry_alpha;
    logic [ChanW-1:0] src_index;
    logic [ChanW-1:0] back_blue;
    logic [ChanW-1:0] back_green;
    logic [ChanW-1:0] back_red;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
  } pix_out_t;

  typedef struct packed {
    logic copy;
    logic key_hit;
  } flags_t;

  function automatic logic [ChanW-1:0] scale_alpha(input logic [ChanW-1:0] a,
                                                   input logic [ChanW-1:0] s);
    logic [2*ChanW:0] prod;
    prod = {{(ChanW+1){1'b0}}, a} * ({{(ChanW+1){1'b0}}, s} + {{(2*ChanW){1'b0}}, 1'b1});
    return prod[2*ChanW-1:ChanW];
  endfunction

endpackage

// ----- design/abck_mix.sv -----
module abck_mix (
  input  logic [abck_pkg::ChanW-1:0] back_i,
  input  logic [abck_pkg::ChanW-1:0] src_i,
  input  logic [abck_pkg::ChanW-1:0] alpha_i,
  output logic [abck_pkg::ChanW-1:0] mix_o
);
  import abck_pkg::*;

  logic [2*ChanW-1:0] back_part;
  logic [2*ChanW-1:0] src_part;
  logic [2*ChanW-1:0] sum;

  assign back_part = {{ChanW{1'b0}}, back_i} * {{ChanW{1'b0}}, AlphaOpaque - alpha_i};
  assign src_part = {{ChanW{1'b0}}, src_i} * {{ChanW{1'b0}}, alpha_i};
  assign sum = back_part + src_part;
  assign mix_o = sum[2*ChanW-1:ChanW];

endmodule

// ----- design/alpha_blend_color_key.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i (abck_pkg::pix_in_t)
// out      output     out_valid_o / out_stall_i out_data_o (abck_pkg::pix_out_t)
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One pixel is accepted every clock unless in_stall_o is high; a result leaves from the output register.
// Stage one scales alpha by the global maximum and compares the key, stage two
// applies palette alpha, stage three puts the mix, source or background into the output register.
// Reset clears the valid bits and loads the register defaults.
// A stall on the output holds the full stages; empty stages still fill behind it.
module alpha_blend_color_key (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  abck_pkg::pix_in_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output abck_pkg::pix_out_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [abck_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [abck_pkg::CfgDataW-1:0]    cfg_data_i
);
  import abck_pkg::*;

  logic [ChanW-1:0] alpha_max_q;
  logic             alpha_chan_on_q;
  logic             palette_mode_q;
  logic             palette_alpha_on_q;
  logic             key_enable_q;
  logic [KeyW-1:0]  key_color_q;
  logic [ChanW-1:0] key_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_max_q <= AlphaOpaque;
      alpha_chan_on_q <= 1'b0;
      palette_mode_q <= 1'b0;
      palette_alpha_on_q <= 1'b0;
      key_enable_q <= 1'b0;
      key_color_q <= '0;
      key_index_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAlphaMax: alpha_max_q <= cfg_data_i[ChanW-1:0];
        RegAlphaChanOn: alpha_chan_on_q <= cfg_data_i[0];
        RegPaletteMode: palette_mode_q <= cfg_data_i[0];
        RegPaletteAlphaOn: palette_alpha_on_q <= cfg_data_i[0];
        RegKeyEnable: key_enable_q <= cfg_data_i[0];
        RegKeyColor: key_color_q <= cfg_data_i[KeyW-1:0];
        RegKeyIndex: key_index_q <= cfg_data_i[ChanW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic     s1_valid_q, s2_valid_q, s3_valid_q;
  logic     s1_adv, s2_adv, s3_adv;
  logic     s1_load, s2_load, s3_load;
  pix_in_t  s1_pix_q, s2_pix_q;
  flags_t   s1_flags_q, s2_flags_q;
  flags_t   s1_flags_d;
  logic [ChanW-1:0] s1_alpha_q, s2_alpha_q;
  logic [ChanW-1:0] s1_alpha_d, s2_alpha_d;
  logic [ChanW-1:0] alpha_base;
  logic             key_match;
  pix_out_t         out_q, out_d;
  logic [ChanW-1:0] mix_b, mix_g, mix_r;

  assign s3_adv = !s3_valid_q || !out_stall_i;
  assign s2_adv = !s2_valid_q || s3_adv;
  assign s1_adv = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign s1_load = in_valid_i && s1_adv;
  assign s2_load = s1_valid_q && s2_adv;
  assign s3_load = s2_valid_q && s3_adv;

  assign alpha_base = alpha_chan_on_q ? in_data_i.src_alpha : AlphaOpaque;
  assign s1_alpha_d = scale_alpha(alpha_base, alpha_max_q);
  assign key_match = palette_mode_q ? (in_data_i.src_index == key_index_q) :
      ({in_data_i.src_red, in_data_i.src_green, in_data_i.src_blue} == key_color_q);
  assign s1_flags_d.copy = !(key_enable_q || alpha_chan_on_q || palette_alpha_on_q);
  assign s1_flags_d.key_hit = key_enable_q && key_match;

  assign s2_alpha_d = (palette_mode_q && palette_alpha_on_q) ?
      scale_alpha(s1_alpha_q, s1_pix_q.entry_alpha) : s1_alpha_q;

  abck_mix u_mix_b (
    .back_i (s2_pix_q.back_blue),
    .src_i  (s2_pix_q.src_blue),
    .alpha_i(s2_alpha_q),
    .mix_o  (mix_b)
  );

  abck_mix u_mix_g (
    .back_i (s2_pix_q.back_green),
    .src_i  (s2_pix_q.src_green),
    .alpha_i(s2_alpha_q),
    .mix_o  (mix_g)
  );

  abck_mix u_mix_r (
    .back_i (s2_pix_q.back_red),
    .src_i  (s2_pix_q.src_red),
    .alpha_i(s2_alpha_q),
    .mix_o  (mix_r)
  );

  always_comb begin
    if (s2_flags_q.copy || (!s2_flags_q.key_hit && s2_alpha_q == AlphaOpaque)) begin
      out_d = '{out_blue: s2_pix_q.src_blue, out_green: s2_pix_q.src_green,
                out_red: s2_pix_q.src_red};
    end else if (s2_flags_q.key_hit || s2_alpha_q == AlphaClear) begin
      out_d = '{out_blue: s2_pix_q.back_blue, out_green: s2_pix_q.back_green,
                out_red: s2_pix_q.back_red};
    end else begin
      out_d = '{out_blue: mix_b, out_green: mix_g, out_red: mix_r};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
      if (s3_adv) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pix_q <= in_data_i;
      s1_alpha_q <= s1_alpha_d;
      s1_flags_q <= s1_flags_d;
    end
    if (s2_load) begin
      s2_pix_q <= s1_pix_q;
      s2_alpha_q <= s2_alpha_d;
      s2_flags_q <= s1_flags_q;
    end
    if (s3_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_copy_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s3_load && s2_flags_q.copy) |=>
      (out_data_o.out_red == $past(s2_pix_q.src_red) &&
       out_data_o.out_blue == $past(s2_pix_q.src_blue)))
    else $error("plain copy did not pass the source color");

  a_key_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s3_load && s2_flags_q.key_hit && !s2_flags_q.copy) |=>
      (out_data_o.out_green == $past(s2_pix_q.back_green)))
    else $error("key match did not keep the background");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s2_valid_q && !s3_adv) |=> (s2_valid_q && $stable(s2_alpha_q)))
    else $error("blocked stage two lost its item");

endmodule
